FILE: rtl/mnee_pkg.sv
// ----------------------------------------------------------------------------
// mnee_pkg
// Shared types, constants and the VLQ packing function for the MIDI note
// event encoder.
// ----------------------------------------------------------------------------
package mnee_pkg;

	localparam int unsigned TICK_W = 28;
	localparam logic [TICK_W-1:0] DELTA_MAX = 28'hFFF_FFFF;
	localparam logic [15:0] DEFAULT_BPM = 16'd120;

	// floor(x / 125) = (x * recip) >> shift, exact over the operand range
	localparam logic [16:0] BH_RECIP = 17'd67109;     // 16-bit operand, shift 23
	localparam logic [23:0] LO_RECIP = 24'd8589935;   // 23-bit operand, shift 30

	localparam logic [7:0] EV_NOTE_ON  = 8'h90;
	localparam logic [7:0] EV_NOTE_OFF = 8'h80;
	localparam logic [7:0] EV_META     = 8'hFF;
	localparam logic [7:0] META_EOT    = 8'h2F;
	localparam logic [7:0] BYTE_ZERO   = 8'h00;

	localparam logic KIND_NOTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef struct packed {
		logic        kind;
		logic        silent;       // rest flag or zero frequency
		logic [15:0] ms;
		logic [6:0]  note;
		logic [6:0]  vel;
	} item_t;

	typedef struct packed {
		item_t             item;
		logic [TICK_W-1:0] ticks;
	} tick_item_t;

	typedef struct packed {
		logic [3:0][7:0] b;         // b[k] is the k-th byte sent
		logic [1:0]      last_idx;  // index of the final byte
	} vlq_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_DELTA,
		PH_ON,
		PH_TICKS,
		PH_OFF,
		PH_END
	} phase_t;

	function automatic vlq_t vlq_enc(input logic [TICK_W-1:0] v);
		vlq_t r;
		r.b = '0;
		if (v[27:21] != 7'd0) begin
			r.last_idx = 2'd3;
			r.b[0] = {1'b1, v[27:21]};
			r.b[1] = {1'b1, v[20:14]};
			r.b[2] = {1'b1, v[13:7]};
			r.b[3] = {1'b0, v[6:0]};
		end else if (v[20:14] != 7'd0) begin
			r.last_idx = 2'd2;
			r.b[0] = {1'b1, v[20:14]};
			r.b[1] = {1'b1, v[13:7]};
			r.b[2] = {1'b0, v[6:0]};
		end else if (v[13:7] != 7'd0) begin
			r.last_idx = 2'd1;
			r.b[0] = {1'b1, v[13:7]};
			r.b[1] = {1'b0, v[6:0]};
		end else begin
			r.last_idx = 2'd0;
			r.b[0] = {1'b0, v[6:0]};
		end
		return r;
	endfunction

endpackage

FILE: rtl/midi_note_event_encoder_core.sv
// ----------------------------------------------------------------------------
// midi_note_event_encoder_core
// Converts note, rest and end items into MIDI track event bytes.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle into the five-stage tick pipeline while it is
// not stalled; the byte emitter sends one byte per cycle while out_ready is
// high, and a note or end item holds it until its last byte is taken, while
// a rest is handed off with no byte.
// Reset: pipeline empty, pending delta zero, tempo 120 bpm, emitter idle.
module midi_note_event_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] tempo_bpm,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [15:0] dur_ms,
	input  logic        rest_flag,
	input  logic [15:0] pitch_frequency,
	input  logic [7:0]  note_number,
	input  logic [7:0]  note_velocity,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_byte
);

	logic [15:0] tempo_q;
	logic [15:0] bpm_eff;
	logic        en;
	mnee_pkg::item_t in_item;
	logic        p_valid;
	mnee_pkg::tick_item_t p_data;

	mnee_pkg::phase_t phase_q, phase_d;
	logic [1:0]  sub_q, sub_d;
	logic [mnee_pkg::TICK_W-1:0] pending_q;
	logic [mnee_pkg::TICK_W:0]   pend_sum;
	mnee_pkg::vlq_t dvlq_q, tvlq_q;
	logic [6:0]  note_q, vel_q;
	logic        end_q;

	logic hs, done, take_ok, load, emits;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_q <= mnee_pkg::DEFAULT_BPM;
		end else if (cfg_valid) begin
			tempo_q <= tempo_bpm;
		end
	end

	assign bpm_eff = (tempo_q == 16'd0) ? mnee_pkg::DEFAULT_BPM : tempo_q;

	assign in_item.kind   = kind;
	assign in_item.silent = rest_flag | (pitch_frequency == 16'd0);
	assign in_item.ms     = dur_ms;
	assign in_item.note   = note_number[6:0];
	assign in_item.vel    = note_velocity[6:0];

	// stall the whole pipeline while the last stage cannot hand off
	assign en       = !p_valid || take_ok;
	assign in_ready = en;

	mnee_tick_pipe u_tick_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid && in_ready),
		.in_item   (in_item),
		.in_bpm    (bpm_eff),
		.out_valid (p_valid),
		.out_data  (p_data)
	);

	// byte emitter
	assign out_valid = (phase_q != mnee_pkg::PH_IDLE);
	assign hs        = out_valid && out_ready;
	assign done      = hs && last_byte;
	assign take_ok   = (phase_q == mnee_pkg::PH_IDLE) || done;
	assign load      = p_valid && take_ok;
	assign emits     = (p_data.item.kind == mnee_pkg::KIND_END) || !p_data.item.silent;
	assign pend_sum  = {1'b0, pending_q} + {1'b0, p_data.ticks};

	always_comb begin
		out_byte  = mnee_pkg::BYTE_ZERO;
		last_byte = 1'b0;
		phase_d   = phase_q;
		sub_d     = sub_q;
		case (phase_q)
			mnee_pkg::PH_DELTA: begin
				out_byte = dvlq_q.b[sub_q];
				if (hs) begin
					if (sub_q == dvlq_q.last_idx) begin
						if (end_q) begin
							phase_d = mnee_pkg::PH_END;
						end else begin
							phase_d = mnee_pkg::PH_ON;
						end
						sub_d   = 2'd0;
					end else begin
						sub_d = sub_q + 2'd1;
					end
				end
			end
			mnee_pkg::PH_ON: begin
				case (sub_q)
					2'd0:    out_byte = mnee_pkg::EV_NOTE_ON;
					2'd1:    out_byte = {1'b0, note_q};
					default: out_byte = {1'b0, vel_q};
				endcase
				if (hs) begin
					if (sub_q == 2'd2) begin
						phase_d = mnee_pkg::PH_TICKS;
						sub_d   = 2'd0;
					end else begin
						sub_d = sub_q + 2'd1;
					end
				end
			end
			mnee_pkg::PH_TICKS: begin
				out_byte = tvlq_q.b[sub_q];
				if (hs) begin
					if (sub_q == tvlq_q.last_idx) begin
						phase_d = mnee_pkg::PH_OFF;
						sub_d   = 2'd0;
					end else begin
						sub_d = sub_q + 2'd1;
					end
				end
			end
			mnee_pkg::PH_OFF, mnee_pkg::PH_END: begin
				case (sub_q)
					2'd0: begin
						out_byte = (phase_q == mnee_pkg::PH_OFF) ? mnee_pkg::EV_NOTE_OFF
						                                         : mnee_pkg::EV_META;
					end
					2'd1: begin
						out_byte = (phase_q == mnee_pkg::PH_OFF) ? {1'b0, note_q}
						                                         : mnee_pkg::META_EOT;
					end
					default: out_byte = mnee_pkg::BYTE_ZERO;
				endcase
				last_byte = (sub_q == 2'd2);
				if (hs) begin
					if (sub_q == 2'd2) begin
						phase_d = mnee_pkg::PH_IDLE;
						sub_d   = 2'd0;
					end else begin
						sub_d = sub_q + 2'd1;
					end
				end
			end
			default: begin
				phase_d = mnee_pkg::PH_IDLE;
				sub_d   = 2'd0;
			end
		endcase
		// a rest leaves the emitter as it would be without it
		if (load && emits) begin
			phase_d = mnee_pkg::PH_DELTA;
			sub_d   = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= mnee_pkg::PH_IDLE;
			sub_q     <= 2'd0;
			pending_q <= '0;
		end else begin
			phase_q <= phase_d;
			sub_q   <= sub_d;
			if (load) begin
				if (emits) begin
					pending_q <= '0;
				end else if (pend_sum[mnee_pkg::TICK_W]) begin
					pending_q <= mnee_pkg::DELTA_MAX;
				end else begin
					pending_q <= pend_sum[mnee_pkg::TICK_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && emits) begin
			dvlq_q <= mnee_pkg::vlq_enc(pending_q);
			tvlq_q <= mnee_pkg::vlq_enc(p_data.ticks);
			note_q <= p_data.item.note;
			vel_q  <= p_data.item.vel;
			end_q  <= (p_data.item.kind == mnee_pkg::KIND_END);
		end
	end

	a_delta_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == mnee_pkg::PH_DELTA) |-> (sub_q <= dvlq_q.last_idx))
		else $error("delta byte index past its length");

	a_ticks_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == mnee_pkg::PH_TICKS) |-> (sub_q <= tvlq_q.last_idx))
		else $error("tick byte index past its length");

	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		(load && emits) |=> (phase_q == mnee_pkg::PH_DELTA && sub_q == 2'd0))
		else $error("emitting item did not start with its delta");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(p_valid && !take_ok) |-> !in_ready)
		else $error("input taken while pipeline output is blocked");

	a_rest_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(load && emits) |=> (pending_q == '0))
		else $error("pending delta not cleared after emitting item");

endmodule

FILE: rtl/mnee_tick_pipe.sv
// ----------------------------------------------------------------------------
// mnee_tick_pipe
// Five-stage pipeline converting the duration in ms to ticks as
// floor(ms * bpm / 125), minimum 1. bpm = 125*bh + bl, so the quotient is
// ms*bh + floor(ms*bl / 125), with both divisions done by reciprocal multiply.
// ----------------------------------------------------------------------------
module mnee_tick_pipe (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  mnee_pkg::item_t        in_item,
	input  logic [15:0]            in_bpm,
	output logic                   out_valid,
	output mnee_pkg::tick_item_t   out_data
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	mnee_pkg::item_t item_s1, item_s2, item_s3, item_s4, item_s5;

	logic [15:0] bpm_s1, bpm_s2;
	logic [9:0]  bh_s2;
	logic [6:0]  bl_s3;
	logic [25:0] phi_s3, phi_s4, phi_s5;
	logic [22:0] plo_s4;
	logic [15:0] qlo_s5;

	logic [32:0] bh_prod;
	logic [15:0] bh_x125;
	logic [15:0] bl_full;
	logic [25:0] phi;
	logic [22:0] plo;
	logic [46:0] qlo_prod;
	logic [25:0] ticks_raw;

	assign bh_prod  = {17'd0, bpm_s1} * {16'd0, mnee_pkg::BH_RECIP};
	assign bh_x125  = ({6'd0, bh_s2} << 7) - ({6'd0, bh_s2} << 1) - {6'd0, bh_s2};
	assign bl_full  = bpm_s2 - bh_x125;
	assign phi      = {10'd0, item_s2.ms} * {16'd0, bh_s2};
	assign plo      = {7'd0, item_s3.ms} * {16'd0, bl_s3};
	assign qlo_prod = {24'd0, plo_s4} * {23'd0, mnee_pkg::LO_RECIP};
	assign ticks_raw = phi_s5 + {10'd0, qlo_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_item;
			bpm_s1  <= in_bpm;
			item_s2 <= item_s1;
			bpm_s2  <= bpm_s1;
			bh_s2   <= bh_prod[32:23];
			item_s3 <= item_s2;
			bl_s3   <= bl_full[6:0];
			phi_s3  <= phi;
			item_s4 <= item_s3;
			plo_s4  <= plo;
			phi_s4  <= phi_s3;
			item_s5 <= item_s4;
			qlo_s5  <= qlo_prod[45:30];
			phi_s5  <= phi_s4;
		end
	end

	assign out_valid     = v_s5;
	assign out_data.item = item_s5;
	assign out_data.ticks = (ticks_raw == 26'd0) ? 28'd1 : {2'd0, ticks_raw};

endmodule

FILE: test/midi_note_event_encoder_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midi_note_event_encoder_core_tb
// Drives note, rest and end items into the encoder and checks each track byte
// and its last flag against a local byte predictor or a row's own bytes.
// Directed rows first, then random phases at several tempos, idling both sides.
// ----------------------------------------------------------------------------
module midi_note_event_encoder_core_tb;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE_CYCLES = 24;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned N_DIR = 26;
	localparam int unsigned N_PHASE = 5;
	localparam int unsigned PHASE_ITEMS = 37;
	localparam logic [27:0] SAT_MAX = 28'hFFF_FFFF;
	localparam logic [63:0] TICKS_PER_BEAT = 64'd480;
	localparam logic [63:0] MS_PER_MIN = 64'd60000;

	typedef struct packed {
		logic        kind;
		logic [15:0] ms;
		logic        rest;
		logic [15:0] freq;
		logic [7:0]  note;
		logic [7:0]  vel;
	} event_item_t;

	typedef struct packed {
		logic [7:0] val;
		logic       last;
	} out_beat_t;

	typedef struct packed {
		logic         set_tempo;
		logic [15:0]  bpm;
		event_item_t  ev;
		logic         typed;
		logic [3:0]   n_exp;
		logic [111:0] exp_bytes;  // right-aligned, first byte highest
	} dir_row_t;

	typedef logic [7:0] byte_list_t [$];

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] tempo_bpm;
	logic        in_valid;
	logic        in_ready;
	logic        kind;
	logic [15:0] dur_ms;
	logic        rest_flag;
	logic [15:0] pitch_frequency;
	logic [7:0]  note_number;
	logic [7:0]  note_velocity;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        last_byte;

	out_beat_t   expect_q [$];
	logic [15:0] tempo_q;
	logic [27:0] delta_q;
	int unsigned err_count;
	int unsigned cycle_cnt;
	bit          throttle_en;
	bit          hold_req;
	dir_row_t    dir_tbl [N_DIR];
	logic [15:0] phase_bpm [N_PHASE];

	midi_note_event_encoder_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.tempo_bpm       (tempo_bpm),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.dur_ms          (dur_ms),
		.rest_flag       (rest_flag),
		.pitch_frequency (pitch_frequency),
		.note_number     (note_number),
		.note_velocity   (note_velocity),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_byte        (out_byte),
		.last_byte       (last_byte)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("midi_note_event_encoder_core verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic logic [27:0] ticks_of(input logic [15:0] ms);
		logic [63:0] t;
		logic [15:0] bpm;
		bpm = (tempo_q == 16'd0) ? mnee_pkg::DEFAULT_BPM : tempo_q;
		t = (64'(ms) * TICKS_PER_BEAT * 64'(bpm)) / MS_PER_MIN;
		if (t == 64'd0)
			t = 64'd1;
		if (t > 64'(SAT_MAX))
			t = 64'(SAT_MAX);
		return t[27:0];
	endfunction

	function automatic void add_vlq(ref byte_list_t bl, input logic [27:0] v);
		for (int k = 3; k >= 1; k--) begin
			if ((v >> (7 * k)) != 28'd0)
				bl.insert(bl.size(), {1'b1, v[7 * k +: 7]});
		end
		bl.insert(bl.size(), {1'b0, v[6:0]});
	endfunction

	// Advance the pending delta and return the track bytes one item produces.
	function automatic void predict_bytes(input event_item_t ev, output byte_list_t bl);
		logic [27:0] ticks;
		logic [28:0] sum;
		bl = {};
		if (ev.kind == mnee_pkg::KIND_END) begin
			add_vlq(bl, delta_q);
			bl.insert(bl.size(), mnee_pkg::EV_META);
			bl.insert(bl.size(), mnee_pkg::META_EOT);
			bl.insert(bl.size(), mnee_pkg::BYTE_ZERO);
			delta_q = '0;
			return;
		end
		ticks = ticks_of(ev.ms);
		if (ev.rest || ev.freq == 16'd0) begin
			sum = {1'b0, delta_q} + {1'b0, ticks};
			delta_q = (sum > {1'b0, SAT_MAX}) ? SAT_MAX : sum[27:0];
			return;
		end
		add_vlq(bl, delta_q);
		bl.insert(bl.size(), mnee_pkg::EV_NOTE_ON);
		bl.insert(bl.size(), {1'b0, ev.note[6:0]});
		bl.insert(bl.size(), {1'b0, ev.vel[6:0]});
		add_vlq(bl, ticks);
		bl.insert(bl.size(), mnee_pkg::EV_NOTE_OFF);
		bl.insert(bl.size(), {1'b0, ev.note[6:0]});
		bl.insert(bl.size(), mnee_pkg::BYTE_ZERO);
		delta_q = '0;
	endfunction

	function automatic dir_row_t mk_row(input logic set_tempo, input logic [15:0] bpm,
			input logic k, input logic [15:0] ms, input logic rest, input logic [15:0] freq,
			input logic [7:0] note, input logic [7:0] vel, input logic typed,
			input logic [3:0] n_exp, input logic [111:0] exp_bytes);
		dir_row_t r;
		r.set_tempo = set_tempo;
		r.bpm = bpm;
		r.ev = '{kind: k, ms: ms, rest: rest, freq: freq, note: note, vel: vel};
		r.typed = typed;
		r.n_exp = n_exp;
		r.exp_bytes = exp_bytes;
		return r;
	endfunction

	function automatic event_item_t rand_event();
		event_item_t ev;
		int unsigned sel;
		sel = $urandom_range(0, 99);
		ev.kind = (sel < 10) ? mnee_pkg::KIND_END : mnee_pkg::KIND_NOTE;
		ev.rest = (sel >= 10 && sel < 25);
		case ($urandom_range(0, 9))
			0: ev.ms = 16'($urandom_range(0, 3));
			1: ev.ms = 16'hFFFF;
			2, 3, 4, 5, 6: ev.ms = 16'($urandom_range(1, 2000));
			default: ev.ms = 16'($urandom);
		endcase
		ev.freq = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
		ev.note = 8'($urandom);
		ev.vel = 8'($urandom);
		return ev;
	endfunction

	task automatic write_tempo(input logic [15:0] bpm);
		cfg_valid <= 1'b1;
		tempo_bpm <= bpm;
		do @(posedge clk); while (!cfg_ready);
		tempo_q = bpm;
		cfg_valid <= 1'b0;
	endtask

	// Wait until every expected byte is out, then let the pipeline empty.
	task automatic drain();
		in_valid <= 1'b0;
		while (expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_event(input event_item_t ev, input logic typed, input logic [3:0] n_exp,
			input logic [111:0] exp_bytes);
		byte_list_t bl;
		int unsigned gap;
		out_beat_t beat;
		if (throttle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 9);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= ev.kind;
		dur_ms <= ev.ms;
		rest_flag <= ev.rest;
		pitch_frequency <= ev.freq;
		note_number <= ev.note;
		note_velocity <= ev.vel;
		do @(posedge clk); while (!in_ready);
		predict_bytes(ev, bl);
		if (typed) begin
			bl = {};
			for (int i = 0; i < n_exp; i++)
				bl.insert(bl.size(), exp_bytes[(n_exp - 1 - i) * 8 +: 8]);
		end
		foreach (bl[i]) begin
			beat.val = bl[i];
			beat.last = (i == bl.size() - 1);
			expect_q.insert(expect_q.size(), beat);
		end
	endtask

	always @(posedge clk) begin : byte_monitor
		out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expect_q.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h last %0b", out_byte, last_byte));
			end else begin
				want = expect_q.pop_front();
				if (out_byte !== want.val)
					report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.val));
				if (last_byte !== want.last)
					report_mismatch($sformatf("last_byte %0b, want %0b", last_byte, want.last));
			end
		end
	end

	// Byte sink: random stalls, plus one long hold-off on request.
	initial begin : byte_sink
		int unsigned gap;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (throttle_en && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				gap = $urandom_range(1, 9);
				repeat (gap) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		err_count = 0;
		cycle_cnt = 0;
		throttle_en = 1'b1;
		hold_req = 1'b0;
		tempo_q = mnee_pkg::DEFAULT_BPM;
		delta_q = '0;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		tempo_bpm <= '0;
		in_valid <= 1'b0;
		kind <= mnee_pkg::KIND_NOTE;
		dur_ms <= '0;
		rest_flag <= 1'b0;
		pitch_frequency <= '0;
		note_number <= '0;
		note_velocity <= '0;

		// End right after reset, with every ignored field at its maximum.
		dir_tbl[0] = mk_row(1'b0, 16'd0, mnee_pkg::KIND_END, 16'hFFFF, 1'b1, 16'hFFFF,
			8'hFF, 8'hFF, 1'b1, 4'd4,
			{mnee_pkg::BYTE_ZERO, mnee_pkg::EV_META, mnee_pkg::META_EOT, mnee_pkg::BYTE_ZERO});
		dir_tbl[1] = mk_row(1'b0, 16'd0, mnee_pkg::KIND_NOTE, 16'd1000, 1'b0, 16'd440,
			8'h3C, 8'h64, 1'b1, 4'd9,
			{mnee_pkg::BYTE_ZERO, mnee_pkg::EV_NOTE_ON, 8'h3C, 8'h64, 8'h87, 8'h40,
			mnee_pkg::EV_NOTE_OFF, 8'h3C, mnee_pkg::BYTE_ZERO});
		// Zero duration counts as one tick; note and velocity lose bit 7.
		dir_tbl[2] = mk_row(1'b0, 16'd0, mnee_pkg::KIND_NOTE, 16'd0, 1'b0, 16'd1,
			8'hFF, 8'hFF, 1'b1, 4'd8,
			{mnee_pkg::BYTE_ZERO, mnee_pkg::EV_NOTE_ON, 8'h7F, 8'h7F, 8'h01,
			mnee_pkg::EV_NOTE_OFF, 8'h7F, mnee_pkg::BYTE_ZERO});
		dir_tbl[3] = mk_row(1'b0, 16'd0, mnee_pkg::KIND_NOTE, 16'd0, 1'b0, 16'hFFFF,
			8'h80, 8'h80, 1'b1, 4'd8,
			{mnee_pkg::BYTE_ZERO, mnee_pkg::EV_NOTE_ON, mnee_pkg::BYTE_ZERO,
			mnee_pkg::BYTE_ZERO, 8'h01, mnee_pkg::EV_NOTE_OFF, mnee_pkg::BYTE_ZERO,
			mnee_pkg::BYTE_ZERO});
		dir_tbl[4] = mk_row(1'b0, 16'd0, mnee_pkg::KIND_NOTE, 16'd1000, 1'b1, 16'd440,
			8'h3C, 8'h64, 1'b1, 4'd0, '0);
		// Zero frequency acts as a rest.
		dir_tbl[5] = mk_row(1'b0, 16'd0, mnee_pkg::KIND_NOTE, 16'd125, 1'b0, 16'd0,
			8'h3C, 8'h64, 1'b1, 4'd0, '0);
		dir_tbl[6] = mk_row(1'b0, 16'd0, mnee_pkg::KIND_NOTE, 16'hFFFF, 1'b0, 16'd1000,
			8'h45, 8'h7F, 1'b0, 4'd0, '0);
		dir_tbl[7] = mk_row(1'b0, 16'd0, mnee_pkg::KIND_NOTE, 16'd0, 1'b1, 16'd0,
			8'h00, 8'h00, 1'b1, 4'd0, '0);
		dir_tbl[8] = mk_row(1'b0, 16'd0, mnee_pkg::KIND_END, 16'd0, 1'b0, 16'd0,
			8'h00, 8'h00, 1'b1, 4'd4,
			{8'h01, mnee_pkg::EV_META, mnee_pkg::META_EOT, mnee_pkg::BYTE_ZERO});
		dir_tbl[9] = mk_row(1'b0, 16'd0, mnee_pkg::KIND_NOTE, 16'hFFFF, 1'b1, 16'd300,
			8'h10, 8'h20, 1'b1, 4'd0, '0);
		dir_tbl[10] = mk_row(1'b0, 16'd0, mnee_pkg::KIND_NOTE, 16'hFFFF, 1'b1, 16'd300,
			8'h11, 8'h21, 1'b1, 4'd0, '0);
		dir_tbl[11] = mk_row(1'b0, 16'd0, mnee_pkg::KIND_END, 16'h1234, 1'b0, 16'h5678,
			8'h9A, 8'hBC, 1'b0, 4'd0, '0);
		dir_tbl[12] = mk_row(1'b0, 16'd0, mnee_pkg::KIND_NOTE, 16'd1, 1'b0, 16'hFFFF,
			8'h00, 8'h01, 1'b0, 4'd0, '0);
		dir_tbl[13] = mk_row(1'b0, 16'd0, mnee_pkg::KIND_NOTE, 16'd124, 1'b0, 16'd200,
			8'h7F, 8'h00, 1'b0, 4'd0, '0);
		// Fastest tempo: eight longest rests push the delta into saturation.
		dir_tbl[14] = mk_row(1'b1, 16'hFFFF, mnee_pkg::KIND_NOTE, 16'hFFFF, 1'b1, 16'd880,
			8'h40, 8'h40, 1'b1, 4'd0, '0);
		for (int r = 15; r < 22; r++)
			dir_tbl[r] = mk_row(1'b0, 16'd0, mnee_pkg::KIND_NOTE, 16'hFFFF, 1'b0, 16'd0,
				8'h40, 8'h40, 1'b1, 4'd0, '0);
		dir_tbl[22] = mk_row(1'b0, 16'd0, mnee_pkg::KIND_NOTE, 16'hFFFF, 1'b0, 16'd880,
			8'h40, 8'h40, 1'b0, 4'd0, '0);
		dir_tbl[23] = mk_row(1'b0, 16'd0, mnee_pkg::KIND_END, 16'd0, 1'b1, 16'd0,
			8'h00, 8'h00, 1'b1, 4'd4,
			{mnee_pkg::BYTE_ZERO, mnee_pkg::EV_META, mnee_pkg::META_EOT, mnee_pkg::BYTE_ZERO});
		dir_tbl[24] = mk_row(1'b1, 16'd1, mnee_pkg::KIND_NOTE, 16'd124, 1'b0, 16'd50,
			8'h2A, 8'h55, 1'b1, 4'd8,
			{mnee_pkg::BYTE_ZERO, mnee_pkg::EV_NOTE_ON, 8'h2A, 8'h55, 8'h01,
			mnee_pkg::EV_NOTE_OFF, 8'h2A, mnee_pkg::BYTE_ZERO});
		// Tempo zero falls back to the default.
		dir_tbl[25] = mk_row(1'b1, 16'd0, mnee_pkg::KIND_NOTE, 16'd1000, 1'b0, 16'd440,
			8'h3C, 8'h64, 1'b1, 4'd9,
			{mnee_pkg::BYTE_ZERO, mnee_pkg::EV_NOTE_ON, 8'h3C, 8'h64, 8'h87, 8'h40,
			mnee_pkg::EV_NOTE_OFF, 8'h3C, mnee_pkg::BYTE_ZERO});

		phase_bpm[0] = 16'($urandom_range(30, 300));
		phase_bpm[1] = 16'hFFFF;
		phase_bpm[2] = 16'd0;
		phase_bpm[3] = 16'($urandom);
		phase_bpm[4] = 16'($urandom_range(60, 200));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIR; r++) begin
			if (dir_tbl[r].set_tempo) begin
				drain();
				write_tempo(dir_tbl[r].bpm);
			end
			send_event(dir_tbl[r].ev, dir_tbl[r].typed, dir_tbl[r].n_exp, dir_tbl[r].exp_bytes);
		end

		for (int p = 0; p < N_PHASE; p++) begin
			drain();
			write_tempo(phase_bpm[p]);
			throttle_en = (p != N_PHASE - 1);
			// Long sink hold-off while items keep coming: fills the block.
			if (p == 0)
				hold_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 1 && i == PHASE_ITEMS / 2)
					drain();
				send_event(rand_event(), 1'b0, 4'd0, '0);
			end
		end

		drain();
		if (err_count == 0)
			$display("midi_note_event_encoder_core verification clean");
		else
			$display("midi_note_event_encoder_core verification failed");
		$finish;
	end

endmodule

FILE: midi_note_event_encoder_core.f
rtl/mnee_pkg.sv
rtl/mnee_tick_pipe.sv
rtl/midi_note_event_encoder_core.sv
test/midi_note_event_encoder_core_tb.sv
